// ----- src/scv_pkg.sv -----
`timescale 1ns / 1ps
package scv_pkg;

   localparam int PIX_W     = 8;
   localparam int SUM_W     = 28;
   localparam int ROW_W     = 12;
   localparam int COL_W     = 10;
   localparam int COEF_W    = 16;
   localparam int KDIM      = 3;
   localparam int CSR_W     = 48;
   localparam int CSR_IDX_W = 3;
   localparam int DIM_W     = 13;
   localparam int OFS_W     = 3;
   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 4;
   localparam int PROD_W    = COEF_W + PIX_W + 1;

   localparam logic [DIM_W-1:0] MAX_ROWS   = 13'd4096;
   localparam logic [CSR_W-1:0] COEF_RESET = 48'h071C071C071C;
   localparam logic [15:0]      RECIP3     = 16'd21846;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_TOP = 3'd0,
      CSR_COEF_MID = 3'd1,
      CSR_COEF_BOT = 3'd2,
      CSR_STEP     = 3'd3,
      CSR_PAD      = 3'd4,
      CSR_COLS     = 3'd5,
      CSR_ROWS     = 3'd6
   } csr_idx_type;

   typedef struct packed {
      logic [DIM_W-1:0] q;
      logic [1:0]       rem;
   } qr_type;

   typedef struct packed {
      logic [DIM_W-1:0] cols;
      logic [DIM_W-1:0] rows;
      logic [DIM_W-1:0] out_cols;
      logic [DIM_W-1:0] out_rows;
      logic [2:0]       step;
      logic             pad;
   } geom_type;

   typedef logic [KDIM-1:0][KDIM-1:0][PIX_W-1:0]  win_type;
   typedef logic [KDIM-1:0][KDIM-1:0][COEF_W-1:0] coef_type;

   typedef struct packed {
      win_type               win;
      logic [1:0][OFS_W-1:0] rofs;
      logic [1:0]            rlo;
      logic [1:0][OFS_W-1:0] cofs;
      logic [1:0]            clo;
      logic [1:0][ROW_W-1:0] irow;
      logic [1:0][COL_W-1:0] jcol;
      logic [1:0]            ilast;
      logic [1:0]            jlast;
      logic [1:0]            nr;
      logic [1:0]            nc;
   } job_type;

   // quotient and remainder for a stride of 1 to 4
   function automatic qr_type div_step(input logic [DIM_W-1:0] num, input logic [2:0] step);
      logic [DIM_W+15:0] prod;
      logic [DIM_W:0]    back3;
      logic [DIM_W-1:0]  diff;
      qr_type            res;
      prod    = {16'b0, num} * {{DIM_W{1'b0}}, RECIP3};
      back3   = '0;
      diff    = '0;
      res.q   = num;
      res.rem = 2'd0;
      case (step)
         3'd2: begin
            res.q   = num >> 1;
            res.rem = {1'b0, num[0]};
         end
         3'd3: begin
            res.q   = prod[DIM_W+15:16];
            back3   = {res.q, 1'b0} + {1'b0, res.q};
            diff    = num - back3[DIM_W-1:0];
            res.rem = diff[1:0];
         end
         3'd4: begin
            res.q   = num >> 2;
            res.rem = num[1:0];
         end
         default: ;
      endcase
      return res;
   endfunction

endpackage

// ----- src/strided_padded_conv2d.sv -----
`timescale 1ns / 1ps
// 3x3 correlation over a raster pixel stream, stride 1 to 4, optional one-pixel
// zero border. The input takes one pixel word per clock while full is low; a
// result word leaves per clock while pop is held. A pixel closing windows on
// the right or bottom border yields up to four words, issued one per clock by
// the MAC stage while the result queue has room, so such pixels hold the input
// through full once the four-entry job queue fills. Stages: line store read,
// job queue, multiply register, result queue. Kernel rows hold three signed
// Q2.14 coefficients, column 0 in the low 16 bits; results carry 14 fraction
// bits. Users must write registers only while the block is idle; not enforced.
module strided_padded_conv2d import scv_pkg::*; #(
   parameter int MAX_COLUMNS = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  logic [PIX_W-1:0]        req_pixel,
   output logic                    empty,
   input  logic                    pop,
   output logic signed [SUM_W-1:0] rsp_conv_sum,
   output logic [ROW_W-1:0]        rsp_out_row,
   output logic [COL_W-1:0]        rsp_out_col,
   output logic                    rsp_run_last,
   output logic                    rsp_image_last,
   input  logic                    csr_wen,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_W-1:0]        csr_wdata
);

   logic [CSR_W-1:0] coef_top_ff, coef_mid_ff, coef_bot_ff;
   logic [2:0]       step_ff;
   logic             pad_ff;
   logic [10:0]      cols_ff;
   logic [12:0]      rows_ff;

   geom_type         geom;
   coef_type         coef;
   logic [DIM_W:0]   cols_span, rows_span;
   qr_type           cols_qr, rows_qr;

   logic             accept, busy, job_push, job_pop, job_empty;
   job_type          job_in, job_out;
   logic [$clog2(MID_DEPTH):0] mid_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_top_ff <= COEF_RESET;
         coef_mid_ff <= COEF_RESET;
         coef_bot_ff <= COEF_RESET;
         step_ff     <= 3'd1;
         pad_ff      <= 1'b1;
         cols_ff     <= 11'd1024;
         rows_ff     <= 13'd1024;
      end else if (csr_wen) begin
         case (csr_idx_type'(csr_index))
            CSR_COEF_TOP: coef_top_ff <= csr_wdata;
            CSR_COEF_MID: coef_mid_ff <= csr_wdata;
            CSR_COEF_BOT: coef_bot_ff <= csr_wdata;
            CSR_STEP:     step_ff     <= csr_wdata[2:0];
            CSR_PAD:      pad_ff      <= csr_wdata[0];
            CSR_COLS:     cols_ff     <= csr_wdata[10:0];
            CSR_ROWS:     rows_ff     <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      geom.pad  = pad_ff;
      geom.step = (step_ff == 3'd0) ? 3'd1 : ((step_ff > 3'd4) ? 3'd4 : step_ff);
      if (cols_ff == '0) geom.cols = DIM_W'(1);
      else if (DIM_W'(cols_ff) > DIM_W'(MAX_COLUMNS)) geom.cols = DIM_W'(MAX_COLUMNS);
      else geom.cols = DIM_W'(cols_ff);
      if (rows_ff == '0) geom.rows = DIM_W'(1);
      else if (rows_ff > MAX_ROWS) geom.rows = MAX_ROWS;
      else geom.rows = rows_ff;
      cols_span = {1'b0, geom.cols} + {{(DIM_W-1){1'b0}}, pad_ff, 1'b0};
      rows_span = {1'b0, geom.rows} + {{(DIM_W-1){1'b0}}, pad_ff, 1'b0};
      cols_qr   = div_step(DIM_W'(cols_span - (DIM_W+1)'(KDIM)), geom.step);
      rows_qr   = div_step(DIM_W'(rows_span - (DIM_W+1)'(KDIM)), geom.step);
      geom.out_cols = (cols_span < (DIM_W+1)'(KDIM)) ? '0 : cols_qr.q + DIM_W'(1);
      geom.out_rows = (rows_span < (DIM_W+1)'(KDIM)) ? '0 : rows_qr.q + DIM_W'(1);
      for (int kx = 0; kx < KDIM; kx++) begin
         coef[0][kx] = coef_top_ff[COEF_W*kx +: COEF_W];
         coef[1][kx] = coef_mid_ff[COEF_W*kx +: COEF_W];
         coef[2][kx] = coef_bot_ff[COEF_W*kx +: COEF_W];
      end
   end

   assign full   = (mid_count + ($clog2(MID_DEPTH)+1)'(busy))
                   >= ($clog2(MID_DEPTH)+1)'(MID_DEPTH);
   assign accept = push && !full;

   scv_front #(.MAX_COLUMNS(MAX_COLUMNS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .geom     (geom),
      .accept   (accept),
      .pixel    (req_pixel),
      .busy     (busy),
      .job_push (job_push),
      .job      (job_in)
   );

   scv_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (job_push),
      .din   (job_in),
      .pop   (job_pop),
      .dout  (job_out),
      .empty (job_empty),
      .count (mid_count)
   );

   scv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .coef       (coef),
      .job        (job_out),
      .job_valid  (!job_empty),
      .job_pop    (job_pop),
      .empty      (empty),
      .pop        (pop),
      .conv_sum   (rsp_conv_sum),
      .out_row    (rsp_out_row),
      .out_col    (rsp_out_col),
      .run_last   (rsp_run_last),
      .image_last (rsp_image_last)
   );

endmodule

// ----- src/scv_front.sv -----
`timescale 1ns / 1ps
module scv_front import scv_pkg::*; #(
   parameter int MAX_COLUMNS = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  geom_type         geom,
   input  logic             accept,
   input  logic [PIX_W-1:0] pixel,
   output logic             busy,
   output logic             job_push,
   output job_type          job
);

   localparam int CW = $clog2(MAX_COLUMNS);

   typedef struct packed {
      logic [1:0]            cnt;
      logic [1:0][DIM_W-1:0] idx;
      logic [1:0][OFS_W-1:0] ofs;
      logic [1:0]            lo;
      logic [1:0]            last;
   } axis_type;

   function automatic axis_type pick(input logic [DIM_W-1:0] p, input logic at_end,
                                     input logic [DIM_W-1:0] outn, input logic [2:0] step,
                                     input logic pad);
      logic signed [DIM_W:0] t;
      logic                  t_le0;
      qr_type                qr;
      logic [DIM_W-1:0]      i0;
      logic [DIM_W-1:0]      span;
      logic [OFS_W-1:0]      ofs0;
      axis_type              res;
      t     = $signed({1'b0, p}) + $signed({{DIM_W{1'b0}}, pad}) - $signed(14'sd2);
      t_le0 = t[DIM_W] || (t == '0);
      qr    = div_step(t[DIM_W-1:0], step);
      res   = '0;
      if (!at_end) begin
         i0   = qr.q;
         ofs0 = '0;
      end else begin
         i0   = t_le0 ? '0 : qr.q + DIM_W'(qr.rem != 2'd0);
         ofs0 = t_le0 ? OFS_W'(-t) : ((qr.rem != 2'd0) ? step - {1'b0, qr.rem} : '0);
      end
      span = outn - i0;
      if (i0 < outn) begin
         if (!at_end) begin
            if (!t[DIM_W] && qr.rem == 2'd0) res.cnt = 2'd1;
         end else begin
            res.cnt = (span >= DIM_W'(2)) ? 2'd2 : 2'd1;
         end
      end
      res.idx[0]  = i0;
      res.idx[1]  = i0 + DIM_W'(1);
      res.ofs[0]  = ofs0;
      res.ofs[1]  = ofs0 + step;
      res.lo      = (p == '0) ? 2'd2 : ((p == DIM_W'(1)) ? 2'd1 : 2'd0);
      res.last[0] = (res.idx[0] == outn - DIM_W'(1));
      res.last[1] = (res.idx[1] == outn - DIM_W'(1));
      return res;
   endfunction

   logic [CW-1:0]      col_ff;
   logic [ROW_W-1:0]   row_ff;
   logic [DIM_W-1:0]   c_wide, r_wide;
   logic               c_end, r_end;
   logic [CW-1:0]      c_idx;
   axis_type           rax_in, cax_in;

   logic               v1_ff;
   logic [PIX_W-1:0]   px_ff;
   logic [CW-1:0]      c1_ff;
   axis_type           rax_ff, cax_ff;

   logic [2*PIX_W-1:0] line_mem [MAX_COLUMNS];
   logic [2*PIX_W-1:0] rd_ff;
   logic               fwd_ff;
   logic [2*PIX_W-1:0] fwd_data_ff;
   logic [2*PIX_W-1:0] above, wr_data;
   win_type            win_ff, win_in;
   logic [KDIM-1:0][PIX_W-1:0] new_col;

   assign c_wide = (DIM_W'(col_ff) < geom.cols) ? DIM_W'(col_ff) : geom.cols - DIM_W'(1);
   assign r_wide = (DIM_W'(row_ff) < geom.rows) ? DIM_W'(row_ff) : geom.rows - DIM_W'(1);
   assign c_end  = (c_wide == geom.cols - DIM_W'(1));
   assign r_end  = (r_wide == geom.rows - DIM_W'(1));
   assign c_idx  = c_wide[CW-1:0];
   assign rax_in = pick(r_wide, r_end, geom.out_rows, geom.step, geom.pad);
   assign cax_in = pick(c_wide, c_end, geom.out_cols, geom.step, geom.pad);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         v1_ff  <= 1'b0;
         fwd_ff <= 1'b0;
      end else begin
         v1_ff  <= accept;
         fwd_ff <= accept && v1_ff && (c_idx == c1_ff);
         if (accept) begin
            if (c_end) begin
               col_ff <= '0;
               row_ff <= r_end ? '0 : r_wide[ROW_W-1:0] + ROW_W'(1);
            end else begin
               col_ff <= c_idx + CW'(1);
               row_ff <= r_wide[ROW_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= wr_data;
      if (accept) begin
         px_ff  <= pixel;
         c1_ff  <= c_idx;
         rax_ff <= rax_in;
         cax_ff <= cax_in;
      end
   end

   // line store: {row r-2, row r-1} per column
   always_ff @(posedge clock) begin
      if (accept) rd_ff <= line_mem[c_idx];
      if (v1_ff) line_mem[c1_ff] <= wr_data;
   end

   assign above   = fwd_ff ? fwd_data_ff : rd_ff;
   assign wr_data = {above[PIX_W-1:0], px_ff};
   assign new_col = {px_ff, above[PIX_W-1:0], above[2*PIX_W-1:PIX_W]};

   always_comb begin
      for (int a = 0; a < KDIM; a++) begin
         win_in[a][0] = win_ff[a][1];
         win_in[a][1] = win_ff[a][2];
         win_in[a][2] = new_col[a];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (v1_ff) begin
         win_ff <= win_in;
      end
   end

   always_comb begin
      job.win   = win_in;
      job.rofs  = rax_ff.ofs;
      job.rlo   = rax_ff.lo;
      job.cofs  = cax_ff.ofs;
      job.clo   = cax_ff.lo;
      for (int k = 0; k < 2; k++) begin
         job.irow[k] = rax_ff.idx[k][ROW_W-1:0];
         job.jcol[k] = cax_ff.idx[k][COL_W-1:0];
      end
      job.ilast = rax_ff.last;
      job.jlast = cax_ff.last;
      job.nr    = rax_ff.cnt;
      job.nc    = cax_ff.cnt;
   end

   assign job_push = v1_ff && (rax_ff.cnt != 2'd0) && (cax_ff.cnt != 2'd0);
   assign busy     = v1_ff;

endmodule

// ----- src/scv_queue.sv -----
`timescale 1ns / 1ps
module scv_queue import scv_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  job_type                      din,
   input  logic                         pop,
   output job_type                      dout,
   output logic                         empty,
   output logic [$clog2(MID_DEPTH):0]   count
);

   localparam int PTR_W = $clog2(MID_DEPTH);

   job_type            mem_ff [MID_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]     count_ff;
   logic               do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         count_ff <= count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= din;
   end

   assign dout  = mem_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign count = count_ff;

endmodule

// ----- src/scv_back.sv -----
`timescale 1ns / 1ps
module scv_back import scv_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  coef_type                coef,
   input  job_type                 job,
   input  logic                    job_valid,
   output logic                    job_pop,
   output logic                    empty,
   input  logic                    pop,
   output logic signed [SUM_W-1:0] conv_sum,
   output logic [ROW_W-1:0]        out_row,
   output logic [COL_W-1:0]        out_col,
   output logic                    run_last,
   output logic                    image_last
);

   localparam int OPTR_W = $clog2(OUT_DEPTH);

   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      logic [ROW_W-1:0]        row;
      logic [COL_W-1:0]        col;
      logic                    run_last;
      logic                    image_last;
   } rsp_type;

   typedef logic signed [KDIM-1:0][KDIM-1:0][PROD_W-1:0] prod_type;

   logic                a_ff, b_ff;
   logic                a_last, b_last, job_last, room, issue;
   win_type             pix;
   prod_type            prod_in, prod_ff;
   logic                v_b1_ff;
   logic [ROW_W-1:0]    row_ff;
   logic [COL_W-1:0]    col_ff;
   logic                run_last_ff, image_last_ff;
   logic signed [KDIM-1:0][SUM_W-1:0] row_sum;
   logic signed [SUM_W-1:0] total;

   rsp_type             out_mem_ff [OUT_DEPTH];
   rsp_type             out_word;
   logic [OPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [OPTR_W:0]     cnt_ff;
   logic                do_pop;

   assign a_last   = (job.nr != 2'd2) || a_ff;
   assign b_last   = (job.nc != 2'd2) || b_ff;
   assign job_last = a_last && b_last;
   assign room     = (cnt_ff + (OPTR_W+1)'(v_b1_ff)) < (OPTR_W+1)'(OUT_DEPTH);
   assign issue    = job_valid && room;
   assign job_pop  = issue && job_last;

   always_comb begin
      logic [OFS_W:0] wx, wy;
      for (int ky = 0; ky < KDIM; ky++) begin
         for (int kx = 0; kx < KDIM; kx++) begin
            wx = {1'b0, job.rofs[a_ff]} + (OFS_W+1)'(ky);
            wy = {1'b0, job.cofs[b_ff]} + (OFS_W+1)'(kx);
            if (wx <= (OFS_W+1)'(2) && wx >= (OFS_W+1)'(job.rlo) &&
                wy <= (OFS_W+1)'(2) && wy >= (OFS_W+1)'(job.clo)) begin
               pix[ky][kx] = job.win[wx[1:0]][wy[1:0]];
            end else begin
               pix[ky][kx] = '0;
            end
            prod_in[ky][kx] = $signed(coef[ky][kx]) * $signed({1'b0, pix[ky][kx]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff    <= 1'b0;
         b_ff    <= 1'b0;
         v_b1_ff <= 1'b0;
      end else begin
         v_b1_ff <= issue;
         if (issue) begin
            if (job_last) begin
               a_ff <= 1'b0;
               b_ff <= 1'b0;
            end else if (b_last) begin
               a_ff <= 1'b1;
               b_ff <= 1'b0;
            end else begin
               b_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         prod_ff       <= prod_in;
         row_ff        <= job.irow[a_ff];
         col_ff        <= job.jcol[b_ff];
         run_last_ff   <= job_last;
         image_last_ff <= job.ilast[a_ff] && job.jlast[b_ff];
      end
   end

   always_comb begin
      for (int ky = 0; ky < KDIM; ky++) begin
         row_sum[ky] = SUM_W'($signed(prod_ff[ky][0])) + SUM_W'($signed(prod_ff[ky][1]))
                     + SUM_W'($signed(prod_ff[ky][2]));
      end
      total = row_sum[0] + row_sum[1] + row_sum[2];
   end

   assign out_word = '{sum: total, row: row_ff, col: col_ff,
                       run_last: run_last_ff, image_last: image_last_ff};

   // result queue
   assign do_pop = pop && (cnt_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (v_b1_ff) wr_ptr_ff <= wr_ptr_ff + OPTR_W'(1);
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + OPTR_W'(1);
         cnt_ff <= cnt_ff + (OPTR_W+1)'(v_b1_ff) - (OPTR_W+1)'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (v_b1_ff) out_mem_ff[wr_ptr_ff] <= out_word;
   end

   assign empty      = (cnt_ff == '0);
   assign conv_sum   = out_mem_ff[rd_ptr_ff].sum;
   assign out_row    = out_mem_ff[rd_ptr_ff].row;
   assign out_col    = out_mem_ff[rd_ptr_ff].col;
   assign run_last   = out_mem_ff[rd_ptr_ff].run_last;
   assign image_last = out_mem_ff[rd_ptr_ff].image_last;

   a_rsp_no_overflow: assert property (@(posedge clock) disable iff (reset)
      v_b1_ff |-> (cnt_ff < (OPTR_W+1)'(OUT_DEPTH)) || do_pop)
      else $error("result queue overflow");

   a_iter_in_job: assert property (@(posedge clock) disable iff (reset)
      job_valid |-> (!a_ff || job.nr == 2'd2) && (!b_ff || job.nc == 2'd2))
      else $error("window iterator beyond job");

   a_job_nonempty: assert property (@(posedge clock) disable iff (reset)
      job_valid |-> (job.nr != 2'd0) && (job.nc != 2'd0))
      else $error("job without results");

endmodule

// ----- verif/conv_checker.sv -----
`timescale 1ns / 1ps
module conv_checker import scv_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic                    full,
   input  logic [PIX_W-1:0]        req_pixel,
   input  logic                    empty,
   input  logic                    pop,
   input  logic signed [SUM_W-1:0] rsp_conv_sum,
   input  logic [ROW_W-1:0]        rsp_out_row,
   input  logic [COL_W-1:0]        rsp_out_col,
   input  logic                    rsp_run_last,
   input  logic                    rsp_image_last,
   input  logic                    csr_wen,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_W-1:0]        csr_wdata,
   output int                      errors,
   output int                      pending
);

   localparam int LINE_COLS = 1024;

   typedef struct packed {
      logic [SUM_W-1:0] conv_sum;
      logic [ROW_W-1:0] out_row;
      logic [COL_W-1:0] out_col;
      logic             run_last;
      logic             image_last;
   } sum_word_type;

   sum_word_type sums_due[$];
   logic [47:0] coef_rows[3];
   logic [2:0]  stride_cfg;
   logic        pad_cfg;
   logic [10:0] cols_cfg;
   logic [12:0] rows_cfg;
   logic [7:0]  line_mem[2*LINE_COLS];
   logic [7:0]  win[9];
   int          in_r, in_c;

   assign pending = sums_due.size();

   function automatic int coef_at(int ky, int kx);
      logic signed [15:0] v;
      v = coef_rows[ky][16*kx +: 16];
      return int'(v);
   endfunction

   function automatic int axis_len(int n, int s, int p);
      int num;
      num = n - 3 + 2 * p;
      return num < 0 ? 0 : num / s + 1;
   endfunction

   // output indices whose last needed input index on this axis is pos
   function automatic int axis_pick(int pos, int n, int outn, int s, int p,
                                    output int i0, output int i1);
      int t, k, cnt;
      t = pos + p - 2;
      cnt = 0;
      i0 = 0;
      i1 = 0;
      if (outn <= 0) return 0;
      if (pos < n - 1) begin
         if (t >= 0 && t % s == 0 && t / s < outn) begin
            i0 = t / s;
            cnt = 1;
         end
      end else begin
         k = t <= 0 ? 0 : (t + s - 1) / s;
         for (; k < outn && cnt < 2; k++) begin
            if (cnt == 0) i0 = k;
            else i1 = k;
            cnt++;
         end
      end
      return cnt;
   endfunction

   task automatic model_pixel(input logic [7:0] px);
      int w, h, s, p, c, r, outh, outw, nr, nc, total, n;
      int ri[2], ci[2], i, j, x, y, wx, wy;
      longint acc;
      sum_word_type e;
      w = cols_cfg == 0 ? 1 : (cols_cfg > LINE_COLS ? LINE_COLS : int'(cols_cfg));
      h = rows_cfg == 0 ? 1 : (rows_cfg > 4096 ? 4096 : int'(rows_cfg));
      s = stride_cfg == 0 ? 1 : (stride_cfg > 4 ? 4 : int'(stride_cfg));
      p = pad_cfg;
      c = in_c < w ? in_c : w - 1;
      r = in_r < h ? in_r : h - 1;
      for (int a = 0; a < 3; a++) begin
         win[a*3]   = win[a*3+1];
         win[a*3+1] = win[a*3+2];
      end
      win[2] = line_mem[c];
      win[5] = line_mem[LINE_COLS + c];
      win[8] = px;
      line_mem[c] = line_mem[LINE_COLS + c];
      line_mem[LINE_COLS + c] = px;
      outh = axis_len(h, s, p);
      outw = axis_len(w, s, p);
      nr = axis_pick(r, h, outh, s, p, ri[0], ri[1]);
      nc = axis_pick(c, w, outw, s, p, ci[0], ci[1]);
      total = nr * nc;
      n = 0;
      for (int a = 0; a < nr; a++) begin
         for (int b = 0; b < nc; b++) begin
            i = ri[a];
            j = ci[b];
            acc = 0;
            for (int ky = 0; ky < 3; ky++) begin
               for (int kx = 0; kx < 3; kx++) begin
                  x = i * s - p + ky;
                  y = j * s - p + kx;
                  wx = x - r + 2;
                  wy = y - c + 2;
                  if (x >= 0 && x < h && y >= 0 && y < w &&
                      wx >= 0 && wx < 3 && wy >= 0 && wy < 3)
                     acc += longint'(coef_at(ky, kx)) * longint'(win[wx*3+wy]);
               end
            end
            e.conv_sum   = acc[SUM_W-1:0];
            e.out_row    = i[ROW_W-1:0];
            e.out_col    = j[COL_W-1:0];
            e.run_last   = (n == total - 1);
            e.image_last = (i == outh - 1 && j == outw - 1);
            sums_due.push_back(e);
            n++;
         end
      end
      if (c >= w - 1) begin
         in_c = 0;
         in_r = (r >= h - 1) ? 0 : r + 1;
      end else begin
         in_c = c + 1;
         in_r = r;
      end
   endtask

   always @(posedge clock) begin
      sum_word_type e, got;
      if (reset) begin
         coef_rows  = '{COEF_RESET, COEF_RESET, COEF_RESET};
         stride_cfg = 3'd1;
         pad_cfg    = 1'b1;
         cols_cfg   = 11'd1024;
         rows_cfg   = 13'd1024;
         foreach (line_mem[k]) line_mem[k] = '0;
         foreach (win[k]) win[k] = '0;
         in_r = 0;
         in_c = 0;
         sums_due.delete();
      end else begin
         if (csr_wen) begin
            case (csr_idx_type'(csr_index))
               CSR_COEF_TOP: coef_rows[0] = csr_wdata;
               CSR_COEF_MID: coef_rows[1] = csr_wdata;
               CSR_COEF_BOT: coef_rows[2] = csr_wdata;
               CSR_STEP:     stride_cfg   = csr_wdata[2:0];
               CSR_PAD:      pad_cfg      = csr_wdata[0];
               CSR_COLS:     cols_cfg     = csr_wdata[10:0];
               CSR_ROWS:     rows_cfg     = csr_wdata[12:0];
               default: ;
            endcase
         end
         if (push && !full) model_pixel(req_pixel);
         if (pop && !empty) begin
            got = {rsp_conv_sum, rsp_out_row, rsp_out_col, rsp_run_last, rsp_image_last};
            if (sums_due.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected word: sum %0d row %0d col %0d",
                           rsp_conv_sum, rsp_out_row, rsp_out_col);
            end else begin
               e = sums_due.pop_front();
               if (got !== e) begin
                  errors++;
                  if (errors <= 10)
                     $display({"mismatch: exp sum %0d r %0d c %0d rl %b il %b, ",
                               "got sum %0d r %0d c %0d rl %b il %b"},
                              $signed(e.conv_sum), e.out_row, e.out_col, e.run_last,
                              e.image_last, rsp_conv_sum, rsp_out_row, rsp_out_col,
                              rsp_run_last, rsp_image_last);
               end
            end
         end
      end
   end

   initial errors = 0;

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
module tb;
   import scv_pkg::*;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    push = 1'b0;
   logic                    full;
   logic [PIX_W-1:0]        req_pixel = '0;
   logic                    empty;
   logic                    pop = 1'b0;
   logic signed [SUM_W-1:0] rsp_conv_sum;
   logic [ROW_W-1:0]        rsp_out_row;
   logic [COL_W-1:0]        rsp_out_col;
   logic                    rsp_run_last;
   logic                    rsp_image_last;
   logic                    csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_W-1:0]        csr_wdata = '0;
   int                      errors, pending;
   int                      send_idle = 13, recv_idle = 47;
   int                      sent = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   strided_padded_conv2d uut (.*);
   conv_checker chk (.*);

   always @(posedge clock) pop <= ($urandom_range(99) >= recv_idle);

   function automatic logic [47:0] rand_coefs();
      return 48'({$urandom, $urandom});
   endfunction

   task automatic settle();
      while (pending != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // mode 0: random pixels, 1: alternating 0/255
   task automatic run_image(input logic [47:0] ct, cm, cb, input int step, pad,
                            input int cols, rows, input int mode);
      logic [CSR_W-1:0] vals[7];
      int w, h;
      vals = '{ct, cm, cb, CSR_W'(step), CSR_W'(pad), CSR_W'(cols), CSR_W'(rows)};
      for (int k = 0; k < 7; k++) begin
         csr_wen   <= 1'b1;
         csr_index <= csr_idx_type'(k);
         csr_wdata <= vals[k];
         @(posedge clock);
      end
      csr_wen <= 1'b0;
      w = cols == 0 ? 1 : (cols > 1024 ? 1024 : cols);
      h = rows == 0 ? 1 : (rows > 4096 ? 4096 : rows);
      for (int k = 0; k < w * h; k++) begin
         while ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(posedge clock);
         end
         push      <= 1'b1;
         req_pixel <= mode ? ((k % 2) ? 8'hFF : 8'h00) : 8'($urandom);
         @(negedge clock);
         while (full) @(negedge clock);
         @(posedge clock);
         sent++;
      end
      push <= 1'b0;
      settle();
   endtask

   initial begin
      int base, cols, rows;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // coefficient extremes, pixel extremes
      run_image(48'h800080008000, 48'h800080008000, 48'h800080008000, 1, 1, 3, 3, 1);
      run_image(48'h7FFF7FFF7FFF, 48'h7FFF7FFF7FFF, 48'h7FFF7FFF7FFF, 1, 0, 4, 3, 1);
      run_image(48'h7FFF80007FFF, 48'h80007FFF8000, 48'h000000010000, 2, 1, 5, 4, 0);
      // stride out of range, tiny and empty outputs, zero sizes, narrow strips
      run_image(rand_coefs(), rand_coefs(), rand_coefs(), 0, 1, 2, 2, 0);
      run_image(rand_coefs(), rand_coefs(), rand_coefs(), 7, 1, 6, 5, 0);
      run_image(rand_coefs(), rand_coefs(), rand_coefs(), 5, 0, 9, 9, 0);
      run_image(rand_coefs(), rand_coefs(), rand_coefs(), 1, 0, 2, 2, 0);
      run_image(rand_coefs(), rand_coefs(), rand_coefs(), 4, 0, 0, 0, 0);
      run_image(rand_coefs(), rand_coefs(), rand_coefs(), 3, 1, 13, 3, 0);
      run_image(rand_coefs(), rand_coefs(), rand_coefs(), 4, 1, 1, 11, 0);
      run_image(rand_coefs(), rand_coefs(), rand_coefs(), 1, 1, 1, 20, 0);
      base = sent;
      while (sent - base < 240) begin
         if (sent - base > 160) begin
            send_idle = 0;
            recv_idle = 0;
         end else if (sent - base > 80) begin
            send_idle = 47;
            recv_idle = 13;
         end
         cols = ($urandom_range(9) == 0) ? $urandom_range(13, 20) : $urandom_range(1, 8);
         rows = $urandom_range(1, 6);
         run_image(rand_coefs(), rand_coefs(), rand_coefs(),
                   ($urandom_range(7) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4),
                   $urandom_range(1), cols, rows, 0);
      end
      settle();
      if (errors == 0 && pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #50ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- strided_padded_conv2d.f -----
src/scv_pkg.sv
src/scv_front.sv
src/scv_queue.sv
src/scv_back.sv
src/strided_padded_conv2d.sv
verif/conv_checker.sv
verif/tb.sv
